### rtl/key_binding_combo_turbo_mapper_macros.svh
// ----------------------------------------------------------------------------
// key binding mapper assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef KEY_BINDING_COMBO_TURBO_MAPPER_MACROS_SVH
`define KEY_BINDING_COMBO_TURBO_MAPPER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define KBCTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define KBCTM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/kbctm_pkg.sv
// ----------------------------------------------------------------------------
// kbctm_pkg
// types, constants and helpers shared by the key binding mapper modules
// ----------------------------------------------------------------------------
package kbctm_pkg;

  localparam int unsigned KEY_COUNT = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SLOTS     = 32;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned TURBO_W   = 25;
  localparam int unsigned NUM_TURBO = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned P2_SHIFT  = 16;

  // only keys below KEY_COUNT take part
  localparam logic [63:0]       KEY_MASK_WIDE = (64'd1 << KEY_COUNT) - 64'd1;
  localparam logic [DATA_W-1:0] KEY_MASK      = KEY_MASK_WIDE[DATA_W-1:0];

  localparam logic [DATA_W-1:0] PAD_BYTE_MASK = 32'h0000_00ff;
  localparam logic [DATA_W-1:0] ACT_TURBO_A   = 32'h0000_0100;
  localparam logic [DATA_W-1:0] ACT_TURBO_B   = 32'h0000_0200;
  localparam logic [DATA_W-1:0] ACT_PLAYER2   = 32'h0001_0000;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_BIND  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURBO_RATE  = 2'd0,
    CFG_COMBO_KEYS  = 2'd1,
    CFG_COMBO_ACTS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_KEY,     // unpaired, actions straight from the read port
    ACC_HELD,    // unpaired, actions held from the key read
    ACC_PAIRED   // paired with the partner just read
  } acc_sel_e;

  typedef struct packed {
    logic     load_frame;
    logic     write_bind;
    logic     pick;
    logic     search_first;
    logic     search_next;
    acc_sel_e acc;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic keys_empty;
    logic srch_empty;
    logic rdata_zero;
    logic overlap;
    logic is_combo;
    logic out_free;
  } dp_stat_t;

  // index of the lowest set bit, zero for an empty vector
  function automatic logic [SLOT_W-1:0] lowest_idx(input logic [DATA_W-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/key_binding_combo_turbo_mapper.sv
// ----------------------------------------------------------------------------
// key_binding_combo_turbo_mapper
// maps a frame of pressed keys to two-player pad bits through a binding
// table, with combo key pairing, turbo counters and action edge pulses
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   operation_i key_bits_i bind_slot_i bind_word_i
//   out      out  out_valid_o / out_stall_i pad_bits_o action_pulses_o
//   cfg      in   cfg_we_i                  cfg_idx_i cfg_data_i
//
// a binding write gives no result and leaves the input open
// after its accepting edge a frame stalls the input until its result goes to
// the result register; each walked key and each partner candidate is read in
// turn through the single binding ram read port
// after reset every table entry reads as unbound at once, no clearing pass
// the result register holds a result until taken; the next request is taken
// while it waits, and only the end of that frame waits for the register
// ----------------------------------------------------------------------------
module key_binding_combo_turbo_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kbctm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kbctm_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [kbctm_pkg::DATA_W-1:0]        key_bits_i,
  input  logic [kbctm_pkg::SLOT_W-1:0]        bind_slot_i,
  input  logic [kbctm_pkg::DATA_W-1:0]        bind_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kbctm_pkg::DATA_W-1:0]        pad_bits_o,
  output logic [kbctm_pkg::DATA_W-1:0]        action_pulses_o
);

  kbctm_pkg::dp_cmd_t  cmd;
  kbctm_pkg::dp_stat_t stat;

  kbctm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  kbctm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .key_bits_i      (key_bits_i),
    .bind_slot_i     (bind_slot_i),
    .bind_word_i     (bind_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pad_bits_o      (pad_bits_o),
    .action_pulses_o (action_pulses_o)
  );

endmodule

### rtl/kbctm_ram.sv
// ----------------------------------------------------------------------------
// kbctm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module kbctm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kbctm_dp.sv
// ----------------------------------------------------------------------------
// kbctm_dp
// datapath: binding table, key walk masks, player accumulators, turbo
// counters, config registers and the result register
// ----------------------------------------------------------------------------
`include "key_binding_combo_turbo_mapper_macros.svh"

module kbctm_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  kbctm_pkg::dp_cmd_t                    cmd_i,
  output kbctm_pkg::dp_stat_t                   stat_o,
  input  logic                                  cfg_we_i,
  input  logic [kbctm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [kbctm_pkg::DATA_W-1:0]          cfg_data_i,
  input  logic [kbctm_pkg::DATA_W-1:0]          key_bits_i,
  input  logic [kbctm_pkg::SLOT_W-1:0]          bind_slot_i,
  input  logic [kbctm_pkg::DATA_W-1:0]          bind_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [kbctm_pkg::DATA_W-1:0]          pad_bits_o,
  output logic [kbctm_pkg::DATA_W-1:0]          action_pulses_o
);

  localparam int unsigned DW = kbctm_pkg::DATA_W;
  localparam int unsigned SW = kbctm_pkg::SLOT_W;
  localparam int unsigned TW = kbctm_pkg::TURBO_W;
  localparam int unsigned NT = kbctm_pkg::NUM_TURBO;

  // config
  logic [DW-1:0] turbo_rate_q, combo_keys_q, combo_acts_q;

  // binding table
  logic [kbctm_pkg::SLOTS-1:0] bound_q;
  logic                        rbound_q;
  logic [SW-1:0]               raddr;
  logic [DW-1:0]               ram_rdata;
  logic [DW-1:0]               rdata;

  // walk state
  logic [DW-1:0] keys_q, srch_q, acts_q;
  logic [SW-1:0] k_q, p_q;
  logic [DW-1:0] pl0_q, pl1_q;

  // persistent state and result
  logic [TW-1:0] cnt_q [NT];
  logic [TW-1:0] cnt_sum [NT];
  logic [NT-1:0] hit;
  logic [NT-1:0] tb;
  logic [DW-1:0] prev_q;
  logic          out_valid_q;
  logic [DW-1:0] pad_q, pulses_q;

  logic [DW-1:0] acc_src, acc_filt, pad_calc, frame_acts;
  logic          acc_paired;

  kbctm_ram #(
    .WIDTH (DW),
    .DEPTH (kbctm_pkg::SLOTS)
  ) u_bind_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_bind),
    .waddr_i (bind_slot_i),
    .wdata_i (bind_word_i),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // entries never written read as unbound
  assign rdata = rbound_q ? ram_rdata : '0;

  always_comb begin
    raddr = k_q;
    if (cmd_i.pick || cmd_i.search_first) begin
      raddr = kbctm_pkg::lowest_idx(keys_q);
    end else if (cmd_i.search_next) begin
      raddr = kbctm_pkg::lowest_idx(srch_q);
    end
  end

  // combo filtering and player routing
  always_comb begin
    acc_paired = 1'b0;
    case (cmd_i.acc)
      kbctm_pkg::ACC_KEY:    acc_src = rdata;
      kbctm_pkg::ACC_HELD:   acc_src = acts_q;
      kbctm_pkg::ACC_PAIRED: begin
        acc_src    = acts_q & rdata;
        acc_paired = 1'b1;
      end
      default:               acc_src = '0;
    endcase
    acc_filt = acc_paired ? (acc_src & combo_acts_q) : (acc_src & ~combo_acts_q);
  end

  // turbo lanes: p1 a, p1 b, p2 a, p2 b
  assign hit[0] = |(pl0_q & kbctm_pkg::ACT_TURBO_A);
  assign hit[1] = |(pl0_q & kbctm_pkg::ACT_TURBO_B);
  assign hit[2] = |(pl1_q & kbctm_pkg::ACT_TURBO_A);
  assign hit[3] = |(pl1_q & kbctm_pkg::ACT_TURBO_B);

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      cnt_sum[i] = cnt_q[i] + turbo_rate_q[TW-1:0];
      tb[i]      = hit[i] & cnt_sum[i][TW-1];
    end
    pad_calc = (pl0_q & kbctm_pkg::PAD_BYTE_MASK)
             | ((pl1_q & kbctm_pkg::PAD_BYTE_MASK) << kbctm_pkg::P2_SHIFT)
             | DW'(tb[1:0])
             | (DW'(tb[3:2]) << kbctm_pkg::P2_SHIFT);
    frame_acts = pl0_q | pl1_q;
  end

  // state with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turbo_rate_q <= '0;
      combo_keys_q <= '0;
      combo_acts_q <= '0;
      bound_q      <= '0;
      prev_q       <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (kbctm_pkg::cfg_idx_e'(cfg_idx_i))
          kbctm_pkg::CFG_TURBO_RATE: turbo_rate_q <= cfg_data_i;
          kbctm_pkg::CFG_COMBO_KEYS: combo_keys_q <= cfg_data_i;
          kbctm_pkg::CFG_COMBO_ACTS: combo_acts_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.write_bind) begin
        bound_q[bind_slot_i] <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        prev_q      <= frame_acts;
        for (int i = 0; i < NT; i++) begin
          if (hit[i]) begin
            cnt_q[i] <= cnt_sum[i];
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk_i) begin
    rbound_q <= bound_q[raddr];
    if (cmd_i.load_frame) begin
      keys_q <= key_bits_i & kbctm_pkg::KEY_MASK;
      pl0_q  <= '0;
      pl1_q  <= '0;
    end
    if (cmd_i.pick) begin
      k_q    <= kbctm_pkg::lowest_idx(keys_q);
      keys_q <= keys_q & (keys_q - DW'(1));
    end
    if (cmd_i.search_first) begin
      acts_q <= rdata;
      p_q    <= kbctm_pkg::lowest_idx(keys_q);
      srch_q <= keys_q & (keys_q - DW'(1));
    end
    if (cmd_i.search_next) begin
      p_q    <= kbctm_pkg::lowest_idx(srch_q);
      srch_q <= srch_q & (srch_q - DW'(1));
    end
    if (cmd_i.acc != kbctm_pkg::ACC_NONE) begin
      if (|(acc_filt & kbctm_pkg::ACT_PLAYER2)) begin
        pl1_q <= pl1_q | acc_filt;
      end else begin
        pl0_q <= pl0_q | acc_filt;
      end
      // partner key is consumed and never walked
      if (cmd_i.acc == kbctm_pkg::ACC_PAIRED) begin
        keys_q[p_q] <= 1'b0;
      end
    end
    if (cmd_i.finish) begin
      pad_q    <= pad_calc;
      pulses_q <= frame_acts & ~prev_q;
    end
  end

  assign stat_o.keys_empty = (keys_q == '0);
  assign stat_o.srch_empty = (srch_q == '0);
  assign stat_o.rdata_zero = (rdata == '0);
  assign stat_o.overlap    = |(rdata & acts_q);
  assign stat_o.is_combo   = combo_keys_q[k_q];
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign pad_bits_o      = pad_q;
  assign action_pulses_o = pulses_q;

  `KBCTM_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(cmd_i.finish), "result appeared without finish")
  `KBCTM_ASSERT(a_partner_consumed, (cmd_i.acc == kbctm_pkg::ACC_PAIRED) |=> !keys_q[$past(p_q)], "partner key still pending")
  `KBCTM_NEVER(a_finish_overwrites, cmd_i.finish && out_valid_q && out_stall_i, "pending result overwritten")

endmodule

### rtl/kbctm_ctrl.sv
// ----------------------------------------------------------------------------
// kbctm_ctrl
// controller: issues binding writes, walks the pressed keys, runs the
// partner search and hands the finished frame to the result register
// ----------------------------------------------------------------------------
`include "key_binding_combo_turbo_mapper_macros.svh"

module kbctm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  kbctm_pkg::dp_stat_t stat_i,
  output kbctm_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    PICK,
    KEY_RD,
    PART_RD,
    FINISH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   accept;

  assign accept = in_valid_i && !stall_q;

  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    cmd_o   = '0;
    case (state_q)
      IDLE: begin
        if (accept) begin
          if (operation_i == kbctm_pkg::OP_BIND) begin
            cmd_o.write_bind = 1'b1;
          end else begin
            cmd_o.load_frame = 1'b1;
            state_d          = PICK;
            stall_d          = 1'b1;
          end
        end
      end
      PICK: begin
        if (stat_i.keys_empty) begin
          state_d = FINISH;
        end else begin
          cmd_o.pick = 1'b1;
          state_d    = KEY_RD;
        end
      end
      KEY_RD: begin
        state_d = PICK;
        if (!stat_i.rdata_zero) begin
          if (stat_i.is_combo && !stat_i.keys_empty) begin
            cmd_o.search_first = 1'b1;
            state_d            = PART_RD;
          end else begin
            cmd_o.acc = kbctm_pkg::ACC_KEY;
          end
        end
      end
      PART_RD: begin
        if (stat_i.overlap) begin
          cmd_o.acc = kbctm_pkg::ACC_PAIRED;
          state_d   = PICK;
        end else if (stat_i.srch_empty) begin
          cmd_o.acc = kbctm_pkg::ACC_HELD;
          state_d   = PICK;
        end else begin
          cmd_o.search_next = 1'b1;
        end
      end
      FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = IDLE;
          stall_d      = 1'b0;
        end
      end
      default: begin
        state_d = IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

  `KBCTM_ASSERT(a_open_only_idle, !stall_q |-> (state_q == IDLE), "input open outside idle")
  `KBCTM_ASSERT(a_frame_starts_walk, (accept && operation_i == kbctm_pkg::OP_FRAME) |=> (state_q == PICK), "frame did not start walk")
  `KBCTM_ASSERT(a_finish_when_free, cmd_o.finish |-> stat_i.out_free, "finish with result slot busy")

endmodule
